// ----- rtl/core/crt_pkg.sv -----
// crt_pkg: shared types, codes and defaults for the capability rights table.
// Used by crt_ctrl, crt_datapath and capability_rights_table; depends on nothing.
package crt_pkg;

  localparam int FD_SLOTS_DEF    = 256;
  localparam int RIGHTS_BITS_DEF = 64;

  localparam logic [2:0] OP_LIMIT = 3'd0;
  localparam logic [2:0] OP_GET   = 3'd1;
  localparam logic [2:0] OP_NEW   = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_ENTER = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_INVAL  = 3'd1;
  localparam logic [2:0] ST_BADFD  = 3'd2;
  localparam logic [2:0] ST_NOSLOT = 3'd3;
  localparam logic [2:0] ST_NOTCAP = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  fd;
    logic [63:0] rights;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] rights_out;
    logic [7:0]  new_slot;
    logic        cap_mode;
  } rsp_t;

  typedef struct packed {
    logic load;    // capture a new request, read its slot
    logic busy;    // a captured request is in flight
    logic commit;  // update state and load the response register
  } cmd_t;

endpackage

// ----- rtl/core/crt_ram.sv -----
// crt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module crt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/crt_ctrl.sv -----
// crt_ctrl: request sequencer for the capability rights table.
// Depends on crt_pkg.
module crt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output crt_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic accept;
  logic commit;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign commit    = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign cmd.load   = accept;
  assign cmd.busy   = (state == S_EXEC);
  assign cmd.commit = commit;

endmodule

// ----- rtl/core/crt_datapath.sv -----
// crt_datapath: request registers, valid marks, rights RAM, mode flag and response register.
// Depends on crt_pkg and crt_ram.
module crt_datapath #(
  parameter int FD_SLOTS    = crt_pkg::FD_SLOTS_DEF,
  parameter int RIGHTS_BITS = crt_pkg::RIGHTS_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  crt_pkg::cmd_t cmd,
  input  crt_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata,
  output crt_pkg::rsp_t rsp
);

  localparam int IDX_W = $clog2(FD_SLOTS);

  logic [2:0]             op_r;
  logic [8:0]             fd_r;
  logic [RIGHTS_BITS-1:0] rights_r;
  logic [63:0]            all_rights_mask;
  logic [FD_SLOTS-1:0]    slot_valid;
  logic                   mode_flag;

  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       fd_idx;
  logic [RIGHTS_BITS-1:0] rd_data;
  logic                   in_range;
  logic                   cur_valid;
  logic [RIGHTS_BITS-1:0] eff;
  logic                   found;
  logic [IDX_W-1:0]       free_idx;
  logic [31:0]            free_ext;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [RIGHTS_BITS-1:0] wr_data;
  logic                   mode_next;
  crt_pkg::rsp_t          rsp_next;

  assign fd_idx   = IDX_W'(fd_r);
  assign rd_idx   = cmd.busy ? fd_idx : IDX_W'(req.fd);
  assign in_range = (32'(fd_r) < FD_SLOTS);

  crt_ram #(
    .WIDTH(RIGHTS_BITS),
    .DEPTH(FD_SLOTS)
  ) u_rights (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(wr_data),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  always_comb begin
    cur_valid = in_range ? slot_valid[fd_idx] : 1'b0;
    eff       = cur_valid ? rd_data : all_rights_mask[RIGHTS_BITS-1:0];
  end

  // lowest free slot above fd
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = FD_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i] && (i > 32'(fd_r))) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    free_ext = 32'(free_idx);
  end

  always_comb begin
    wr_en               = 1'b0;
    wr_idx              = fd_idx;
    wr_data             = rights_r;
    mode_next           = mode_flag;
    rsp_next.status     = crt_pkg::ST_OK;
    rsp_next.rights_out = '0;
    rsp_next.new_slot   = '0;
    case (op_r)
      crt_pkg::OP_LIMIT: begin
        if (!in_range) begin
          rsp_next.status = crt_pkg::ST_INVAL;
        end else begin
          wr_en   = 1'b1;
          wr_data = cur_valid ? (rights_r & rd_data) : rights_r;
        end
      end
      crt_pkg::OP_GET: begin
        if (!in_range) begin
          rsp_next.status = crt_pkg::ST_INVAL;
        end else begin
          rsp_next.rights_out = 64'(eff);
        end
      end
      crt_pkg::OP_NEW: begin
        if (!in_range) begin
          rsp_next.status = crt_pkg::ST_BADFD;
        end else if (!found) begin
          rsp_next.status = crt_pkg::ST_NOSLOT;
        end else begin
          wr_en             = 1'b1;
          wr_idx            = free_idx;
          wr_data           = rights_r & eff;
          rsp_next.new_slot = free_ext[7:0];
        end
      end
      crt_pkg::OP_CHECK: begin
        if (!in_range) begin
          rsp_next.status = crt_pkg::ST_BADFD;
        end else if (cur_valid && ((rd_data & rights_r) != rights_r)) begin
          rsp_next.status = crt_pkg::ST_NOTCAP;
        end
      end
      crt_pkg::OP_ENTER: begin
        mode_next = 1'b1;
      end
      default: begin
        rsp_next.status = crt_pkg::ST_INVAL;
      end
    endcase
    wr_en             = wr_en && cmd.commit;
    rsp_next.cap_mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= req.op;
      fd_r     <= req.fd;
      rights_r <= req.rights[RIGHTS_BITS-1:0];
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_rights_mask <= '1;
      slot_valid      <= '0;
      mode_flag       <= 1'b0;
    end else begin
      if (cfg_we) begin
        all_rights_mask <= cfg_wdata;
      end
      if (cmd.commit) begin
        mode_flag <= mode_next;
        if (wr_en) begin
          slot_valid[wr_idx] <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/capability_rights_table.sv -----
// capability_rights_table: per-descriptor rights table with valid marks and capability mode.
// A request transfer reads its slot; the update then commits and loads the response register,
// waiting while a held response is stalled. No new request is taken until that commit.
// A response waiting in the output register does not block the next request transfer.
// Reset (rst, synchronous): all slots invalid, mode cleared, all_rights_mask all ones.
// Depends on crt_pkg, crt_ctrl, crt_datapath and crt_ram.
module capability_rights_table #(
  parameter int FD_SLOTS    = crt_pkg::FD_SLOTS_DEF,
  parameter int RIGHTS_BITS = crt_pkg::RIGHTS_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  crt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output crt_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata
);

  crt_pkg::cmd_t cmd;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd)
  );

  crt_datapath #(
    .FD_SLOTS   (FD_SLOTS),
    .RIGHTS_BITS(RIGHTS_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rsp      (rsp)
  );

endmodule

// ----- test/capability_rights_table_test.sv -----
// capability_rights_table_test: self-checking bench for the capability rights table.
// Mirrors the slot table, the all-rights mask and the mode flag to predict every response.
// Depends on crt_pkg and the capability_rights_table RTL.
module capability_rights_table_test;
  import crt_pkg::*;

  localparam int SLOTS = FD_SLOTS_DEF;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [63:0] WIDTH_MASK =
    (RIGHTS_BITS_DEF >= 64) ? '1 : ((64'd1 << RIGHTS_BITS_DEF) - 64'd1);

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  logic        mirror_valid [SLOTS];
  logic [63:0] mirror_rights [SLOTS];
  logic        mirror_cap_mode;
  logic [63:0] mirror_all_rights;

  rsp_t expected_answers [$];
  int   fail_count = 0;
  bit   calm = 1'b0;
  int   stall_left = 0;

  capability_rights_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] slot_rights_seen(logic [SLOT_W-1:0] slot);
    if (mirror_valid[slot]) begin
      return mirror_rights[slot];
    end
    return mirror_all_rights & WIDTH_MASK;
  endfunction

  // Predicts the response to one request and updates the mirrored table.
  function automatic rsp_t table_answer(req_t item);
    rsp_t              ans;
    logic [63:0]       want;
    logic [63:0]       derived;
    int                free_slot;
    logic [SLOT_W-1:0] slot;
    ans = '0;
    want = item.rights & WIDTH_MASK;
    free_slot = -1;
    slot = SLOT_W'(item.fd);
    case (item.op)
      OP_LIMIT: begin
        if (item.fd >= SLOTS) begin
          ans.status = ST_INVAL;
        end else begin
          mirror_rights[slot] = mirror_valid[slot] ? (want & mirror_rights[slot]) : want;
          mirror_valid[slot] = 1'b1;
        end
      end
      OP_GET: begin
        if (item.fd >= SLOTS) begin
          ans.status = ST_INVAL;
        end else begin
          ans.rights_out = slot_rights_seen(slot);
        end
      end
      OP_NEW: begin
        if (item.fd >= SLOTS) begin
          ans.status = ST_BADFD;
        end else begin
          derived = want & slot_rights_seen(slot);
          for (int i = item.fd + 1; i < SLOTS; i++) begin
            if (!mirror_valid[i] && free_slot < 0) begin
              free_slot = i;
            end
          end
          if (free_slot < 0) begin
            ans.status = ST_NOSLOT;
          end else begin
            mirror_rights[free_slot] = derived;
            mirror_valid[free_slot] = 1'b1;
            ans.new_slot = 8'(free_slot);
          end
        end
      end
      OP_CHECK: begin
        if (item.fd >= SLOTS) begin
          ans.status = ST_BADFD;
        end else if (mirror_valid[slot] && (mirror_rights[slot] & want) != want) begin
          ans.status = ST_NOTCAP;
        end
      end
      OP_ENTER: begin
        mirror_cap_mode = 1'b1;
      end
      default: begin
        ans.status = ST_INVAL;
      end
    endcase
    ans.cap_mode = mirror_cap_mode;
    return ans;
  endfunction

  // Drives one request, returns once the transfer is accepted and queues its expected response.
  task automatic send_request(input logic [2:0] op, input logic [8:0] fd,
                              input logic [63:0] rights);
    req_t item;
    item = '{op: op, fd: fd, rights: rights};
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    expected_answers.push_back(table_answer(item));
  endtask

  task automatic wait_idle;
    req_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_all_rights(input logic [63:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_all_rights = value;
  endtask

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_answers
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %p", $time, rsp);
        fail_count++;
      end else begin
        want = expected_answers.pop_front();
        compare_field("status", 64'(want.status), 64'(rsp.status));
        compare_field("rights_out", want.rights_out, rsp.rights_out);
        compare_field("new_slot", 64'(want.new_slot), 64'(rsp.new_slot));
        compare_field("cap_mode", 64'(want.cap_mode), 64'(rsp.cap_mode));
      end
    end
  end

  // Random receiver back-pressure in bursts, started only when the bench is not calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic test_limit_get;
    send_request(OP_GET, 9'd0, 64'h0);
    send_request(OP_LIMIT, 9'd0, '1);
    send_request(OP_LIMIT, 9'd0, 64'h0F0F_0F0F_F0F0_F0F0);
    send_request(OP_GET, 9'd0, '1);
    send_request(OP_LIMIT, 9'd255, 64'h0);
    send_request(OP_GET, 9'd255, 64'h0);
    send_request(OP_GET, 9'd256, '1);
    send_request(OP_LIMIT, 9'd511, '1);
  endtask

  task automatic test_new_check;
    send_request(OP_CHECK, 9'd5, '1);
    send_request(OP_NEW, 9'd0, '1);
    send_request(OP_NEW, 9'd254, '1);
    send_request(OP_NEW, 9'd255, '1);
    send_request(OP_NEW, 9'd300, '1);
    send_request(OP_CHECK, 9'd0, '1);
    send_request(OP_CHECK, 9'd0, 64'h0F0F_0F0F_F0F0_F0F0);
    send_request(OP_CHECK, 9'd400, 64'h0);
    send_request(OP_NEW, 9'd1, 64'h0);
  endtask

  task automatic test_all_rights_mask;
    write_all_rights(64'h0);
    send_request(OP_GET, 9'd100, '1);
    send_request(OP_NEW, 9'd100, '1);
    send_request(OP_CHECK, 9'd101, '1);
    write_all_rights({$urandom, $urandom});
    send_request(OP_GET, 9'd150, 64'h0);
    send_request(OP_NEW, 9'd150, '1);
    write_all_rights('1);
    send_request(OP_GET, 9'd150, 64'h0);
  endtask

  task automatic test_mode_and_unknown;
    send_request(3'd5, 9'd0, 64'h0);
    send_request(3'd6, 9'd256, '1);
    send_request(3'd7, 9'd511, 64'h0);
    send_request(OP_ENTER, 9'd0, 64'h0);
    send_request(OP_ENTER, 9'd511, '1);
    send_request(OP_GET, 9'd1, 64'h0);
  endtask

  task automatic test_random;
    int                pick;
    logic [2:0]        op;
    logic [8:0]        fd;
    logic [63:0]       rights;
    logic [SLOT_W-1:0] slot;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_all_rights({$urandom, $urandom});
        1: write_all_rights(64'h1);
        2: write_all_rights({$urandom, $urandom} & {$urandom, $urandom});
        3: write_all_rights(64'h8000_0000_0000_0000);
        default: write_all_rights('1);
      endcase
      calm = (phase == 4);
      for (int n = 0; n < 200; n++) begin
        if (phase < 4 && n % 50 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 12) op = OP_LIMIT;
        else if (pick < 40) op = OP_GET;
        else if (pick < 52) op = OP_NEW;
        else if (pick < 82) op = OP_CHECK;
        else if (pick < 87) op = OP_ENTER;
        else if (pick < 92) op = 3'($urandom_range(5, 7));
        else op = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick == 0) fd = 9'($urandom_range(SLOTS, 511));
        else if (pick == 1) fd = 9'($urandom_range(SLOTS - 4, SLOTS - 1));
        else fd = 9'($urandom_range(0, SLOTS - 1));
        slot = SLOT_W'(fd);
        case ($urandom_range(0, 5))
          0: rights = 64'h0;
          1: rights = '1;
          2: rights = 64'd1 << $urandom_range(0, 63);
          3: begin
            if (fd < SLOTS && mirror_valid[slot]) begin
              rights = mirror_rights[slot] & {$urandom, $urandom};
            end else begin
              rights = {$urandom, $urandom};
            end
          end
          default: rights = {$urandom, $urandom};
        endcase
        send_request(op, fd, rights);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_rights[i] = '0;
    end
    mirror_cap_mode = 1'b0;
    mirror_all_rights = '1;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_limit_get();
    test_new_check();
    test_all_rights_mask();
    test_mode_and_unknown();
    test_random();
    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("[capability_rights_table] OK");
    end else begin
      $display("[capability_rights_table] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d responses outstanding", $time, expected_answers.size());
    $display("[capability_rights_table] ERROR");
    $finish;
  end

endmodule
